// ----- sv/cholesky_2x2_hermitian_point_defines.svh -----
// ----------------------------------------------------------------------------
// cholesky 2x2 hermitian point - assertion macros
// shared property forms for the factor pipeline checks
// ----------------------------------------------------------------------------
`ifndef CHOLESKY_2X2_HERMITIAN_POINT_DEFINES_SVH
`define CHOLESKY_2X2_HERMITIAN_POINT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CHF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CHF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/chf_pkg.sv -----
// ----------------------------------------------------------------------------
// chf_pkg
// shared types for the cholesky point pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package chf_pkg;

  // pipeline control handed to each arithmetic unit
  typedef struct packed {
    logic valid;    // item present at the unit input
    logic advance;  // whole pipeline moves this cycle
  } pipe_ctl_t;

  // bits consumed per restoring square root step
  localparam int unsigned SQRT_STEP_BITS = 2;

endpackage

// ----- sv/chf_sqrt_pipe.sv -----
// ----------------------------------------------------------------------------
// chf_sqrt_pipe
// pipelined floor square root of value * 2^frac, one root bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chf_sqrt_pipe #(
  parameter int IN_BITS   = 31,
  parameter int FRAC_BITS = 16,
  parameter int SIDE_BITS = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  chf_pkg::pipe_ctl_t    ctl,
  input  logic [IN_BITS-1:0]    value,
  input  logic [SIDE_BITS-1:0]  side_in,
  output logic                  valid_out,
  output logic [IN_BITS-1:0]    root,
  output logic [SIDE_BITS-1:0]  side_out
);

  localparam int RAD_IN    = IN_BITS + FRAC_BITS;
  localparam int ROOT_BITS = (RAD_IN + 1) / 2;
  localparam int RAD_BITS  = 2 * ROOT_BITS;
  localparam int REM_BITS  = ROOT_BITS + 2;
  localparam int CMP_BITS  = (ROOT_BITS > IN_BITS) ? ROOT_BITS : IN_BITS;
  localparam int STEP      = chf_pkg::SQRT_STEP_BITS;

  logic [RAD_BITS-1:0]  rad_s  [0:ROOT_BITS];
  logic [REM_BITS-1:0]  rem_s  [0:ROOT_BITS];
  logic [ROOT_BITS-1:0] root_s [0:ROOT_BITS];
  logic [SIDE_BITS-1:0] side_s [0:ROOT_BITS];
  logic                 vld_s  [0:ROOT_BITS];

  assign rad_s[0]  = RAD_BITS'({value, {FRAC_BITS{1'b0}}});
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign side_s[0] = side_in;
  assign vld_s[0]  = ctl.valid;

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_step
    logic [REM_BITS-1:0] rem_sh;
    logic [REM_BITS-1:0] trial;
    logic                ge;

    assign rem_sh = {rem_s[i][ROOT_BITS-1:0], rad_s[i][RAD_BITS-1 -: STEP]};
    assign trial  = {root_s[i], 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[i+1] <= 1'b0;
      end else if (ctl.advance) begin
        vld_s[i+1] <= vld_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.advance) begin
        rad_s[i+1]  <= rad_s[i] << STEP;
        rem_s[i+1]  <= ge ? (rem_sh - trial) : rem_sh;
        root_s[i+1] <= {root_s[i][ROOT_BITS-2:0], ge};
        side_s[i+1] <= side_s[i];
      end
    end
  end

  // clip to the output word
  logic [CMP_BITS-1:0] root_ext;
  logic [CMP_BITS-1:0] root_max;
  logic [CMP_BITS-1:0] root_sel;

  assign root_ext = CMP_BITS'(root_s[ROOT_BITS]);
  assign root_max = CMP_BITS'({IN_BITS{1'b1}});
  assign root_sel = (root_ext > root_max) ? root_max : root_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (ctl.advance) begin
      valid_out <= vld_s[ROOT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      root     <= root_sel[IN_BITS-1:0];
      side_out <= side_s[ROOT_BITS];
    end
  end

endmodule

// ----- sv/chf_div_pipe.sv -----
// ----------------------------------------------------------------------------
// chf_div_pipe
// two-lane pipelined signed fixed-point divide by a shared positive divisor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chf_div_pipe #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16,
  parameter int SIDE_BITS = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  chf_pkg::pipe_ctl_t    ctl,
  input  logic [WORD_BITS-1:0]  num_re,
  input  logic [WORD_BITS-1:0]  num_im,
  input  logic [WORD_BITS-2:0]  den,
  input  logic [SIDE_BITS-1:0]  side_in,
  output logic                  valid_out,
  output logic [WORD_BITS-1:0]  quo_re,
  output logic [WORD_BITS-1:0]  quo_im,
  output logic                  ovf,
  output logic [SIDE_BITS-1:0]  side_out
);

  localparam int W      = WORD_BITS;
  localparam int Q_BITS = WORD_BITS + FRAC_BITS;

  logic [Q_BITS-1:0]    dvd_s  [0:Q_BITS][0:1];
  logic [W-1:0]         rem_s  [0:Q_BITS][0:1];
  logic [Q_BITS-1:0]    quo_s  [0:Q_BITS][0:1];
  logic                 neg_s  [0:Q_BITS][0:1];
  logic [W-2:0]         den_s  [0:Q_BITS];
  logic [SIDE_BITS-1:0] side_s [0:Q_BITS];
  logic                 vld_s  [0:Q_BITS];

  // entry register: sign split and magnitude
  logic [W-1:0] num_in [0:1];
  assign num_in[0] = num_re;
  assign num_in[1] = num_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s[0] <= 1'b0;
    end else if (ctl.advance) begin
      vld_s[0] <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      for (int l = 0; l < 2; l++) begin
        neg_s[0][l] <= num_in[l][W-1];
        dvd_s[0][l] <= {(num_in[l][W-1] ? (~num_in[l] + W'(1)) : num_in[l]),
                        {FRAC_BITS{1'b0}}};
        rem_s[0][l] <= '0;
        quo_s[0][l] <= '0;
      end
      den_s[0]  <= den;
      side_s[0] <= side_in;
    end
  end

  for (genvar i = 0; i < Q_BITS; i++) begin : g_step
    logic [W-1:0] rem_sh [0:1];
    logic         ge     [0:1];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        rem_sh[l] = {rem_s[i][l][W-2:0], dvd_s[i][l][Q_BITS-1]};
        ge[l]     = (rem_sh[l] >= {1'b0, den_s[i]});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[i+1] <= 1'b0;
      end else if (ctl.advance) begin
        vld_s[i+1] <= vld_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.advance) begin
        for (int l = 0; l < 2; l++) begin
          dvd_s[i+1][l] <= dvd_s[i][l] << 1;
          rem_s[i+1][l] <= ge[l] ? (rem_sh[l] - {1'b0, den_s[i]}) : rem_sh[l];
          quo_s[i+1][l] <= {quo_s[i][l][Q_BITS-2:0], ge[l]};
          neg_s[i+1][l] <= neg_s[i][l];
        end
        den_s[i+1]  <= den_s[i];
        side_s[i+1] <= side_s[i];
      end
    end
  end

  // saturate and restore sign
  logic [Q_BITS-1:0] lim   [0:1];
  logic              over  [0:1];
  logic [Q_BITS-1:0] q_sat [0:1];
  logic [W-1:0]      q_out [0:1];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      lim[l]   = Q_BITS'({(W-1){1'b1}}) + Q_BITS'(neg_s[Q_BITS][l]);
      over[l]  = (quo_s[Q_BITS][l] > lim[l]);
      q_sat[l] = over[l] ? lim[l] : quo_s[Q_BITS][l];
      q_out[l] = neg_s[Q_BITS][l] ? (~q_sat[l][W-1:0] + W'(1)) : q_sat[l][W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (ctl.advance) begin
      valid_out <= vld_s[Q_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      quo_re   <= q_out[0];
      quo_im   <= q_out[1];
      ovf      <= over[0] | over[1];
      side_out <= side_s[Q_BITS];
    end
  end

endmodule

// ----- sv/cholesky_2x2_hermitian_point.sv -----
// ----------------------------------------------------------------------------
// cholesky_2x2_hermitian_point
// streaming cholesky factor of one 2x2 hermitian matrix point, fixed point
// ----------------------------------------------------------------------------
// Takes p11, complex p21 and p22 as signed Q words and returns a11 =
// sqrt(max(p11, floor)), a21 = p21 / a11 per part and a22 =
// sqrt(max(p22 - |a21|^2, floor)), with roots rounded down, quotients
// truncated toward zero and a21 saturated to the word range. One point is
// accepted every cycle unless the output transfer is stalled; the default
// sizes give Q16.16 words. The pipeline depth is set by the two square root
// pipelines (one root bit per stage) and the divider pipeline (one quotient
// bit per stage). The whole pipeline holds while the output transfer is
// stalled; a floor write of zero is stored as one. The floor register may
// only change while no point is in flight.
`timescale 1ns / 1ps
`include "cholesky_2x2_hermitian_point_defines.svh"

module cholesky_2x2_hermitian_point #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // floor register write
  input  logic                  pivot_floor_we,
  input  logic [WORD_BITS-2:0]  pivot_floor_data,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // diag_first, offdiag_real, offdiag_imag, diag_second
  input  logic [((4*WORD_BITS+7)/8)*8-1:0] s_tdata,
  // output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // root_first, factor_real, factor_imag, root_second,
  // first_clamped, second_clamped, saturated
  output logic [((4*WORD_BITS+1+7)/8)*8-1:0] m_tdata
);

  localparam int W        = WORD_BITS;
  localparam int OUT_BITS = ((4*WORD_BITS+1+7)/8)*8;
  localparam int SIDE1    = 3*W + 1;       // p21 re, p21 im, p22, c1
  localparam int SIDE2    = 2*W;           // p22, c1, a11
  localparam int SIDE3    = 3*W + 2;       // a11, a21 re, a21 im, c1, c2, sat

  // --------------------------------------------------------------------------
  // floor register, zero stands for one
  // --------------------------------------------------------------------------
  logic [W-2:0] floor_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_q <= (W-1)'(1);
    end else if (pivot_floor_we) begin
      floor_q <= (pivot_floor_data == '0) ? (W-1)'(1) : pivot_floor_data;
    end
  end

  // --------------------------------------------------------------------------
  // global advance: the output register is free or being drained
  // --------------------------------------------------------------------------
  logic advance;
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  // --------------------------------------------------------------------------
  // stage a: unpack and clamp p11 to the floor
  // --------------------------------------------------------------------------
  logic [W-1:0] in_p11, in_p21r, in_p21i, in_p22;
  logic         in_c1;

  assign in_p11  = s_tdata[W-1:0];
  assign in_p21r = s_tdata[2*W-1:W];
  assign in_p21i = s_tdata[3*W-1:2*W];
  assign in_p22  = s_tdata[4*W-1:3*W];
  assign in_c1   = $signed(in_p11) < $signed({1'b0, floor_q});

  logic             a_vld;
  logic [W-2:0]     a_v1;
  logic [SIDE1-1:0] a_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (advance) begin
      a_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_v1   <= in_c1 ? floor_q : in_p11[W-2:0];
      a_side <= {in_p21r, in_p21i, in_p22, in_c1};
    end
  end

  // --------------------------------------------------------------------------
  // a11 = sqrt(v1)
  // --------------------------------------------------------------------------
  chf_pkg::pipe_ctl_t sq1_ctl;
  logic               sq1_vld;
  logic [W-2:0]       sq1_root;
  logic [SIDE1-1:0]   sq1_side;

  assign sq1_ctl.valid   = a_vld;
  assign sq1_ctl.advance = advance;

  chf_sqrt_pipe #(
    .IN_BITS   (W-1),
    .FRAC_BITS (FRAC_BITS),
    .SIDE_BITS (SIDE1)
  ) u_sqrt_first (
    .clk       (clk),
    .rst       (rst),
    .ctl       (sq1_ctl),
    .value     (a_v1),
    .side_in   (a_side),
    .valid_out (sq1_vld),
    .root      (sq1_root),
    .side_out  (sq1_side)
  );

  // a zero root would divide by zero, lift it to one lsb
  logic [W-2:0] a11_fix;
  assign a11_fix = (sq1_root == '0) ? (W-1)'(1) : sq1_root;

  // --------------------------------------------------------------------------
  // a21 = p21 / a11, both parts
  // --------------------------------------------------------------------------
  chf_pkg::pipe_ctl_t div_ctl;
  logic               div_vld;
  logic [W-1:0]       div_re, div_im;
  logic               div_ovf;
  logic [SIDE2-1:0]   div_side;

  assign div_ctl.valid   = sq1_vld;
  assign div_ctl.advance = advance;

  chf_div_pipe #(
    .WORD_BITS (W),
    .FRAC_BITS (FRAC_BITS),
    .SIDE_BITS (SIDE2)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .ctl       (div_ctl),
    .num_re    (sq1_side[SIDE1-1 -: W]),
    .num_im    (sq1_side[SIDE1-1-W -: W]),
    .den       (a11_fix),
    .side_in   ({sq1_side[W:1], sq1_side[0], a11_fix}),
    .valid_out (div_vld),
    .quo_re    (div_re),
    .quo_im    (div_im),
    .ovf       (div_ovf),
    .side_out  (div_side)
  );

  // --------------------------------------------------------------------------
  // stage b: squares of the part magnitudes
  // --------------------------------------------------------------------------
  logic [W-1:0] mag_re, mag_im;
  assign mag_re = div_re[W-1] ? (~div_re + W'(1)) : div_re;
  assign mag_im = div_im[W-1] ? (~div_im + W'(1)) : div_im;

  logic             b_vld;
  logic [2*W-1:0]   b_sq_re, b_sq_im;
  logic [W-1:0]     b_re, b_im;
  logic             b_sat;
  logic [SIDE2-1:0] b_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (advance) begin
      b_vld <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_sq_re <= (2*W)'(mag_re) * (2*W)'(mag_re);
      b_sq_im <= (2*W)'(mag_im) * (2*W)'(mag_im);
      b_re    <= div_re;
      b_im    <= div_im;
      b_sat   <= div_ovf;
      b_side  <= div_side;
    end
  end

  // --------------------------------------------------------------------------
  // stage c: |a21|^2, truncated once and saturated to the word
  // --------------------------------------------------------------------------
  logic [2*W:0] mag_sum, mag_shr;
  logic         mag_over;

  assign mag_sum  = {1'b0, b_sq_re} + {1'b0, b_sq_im};
  assign mag_shr  = mag_sum >> FRAC_BITS;
  assign mag_over = (mag_shr > (2*W+1)'({(W-1){1'b1}}));

  logic             c_vld;
  logic [W-2:0]     c_mag;
  logic [W-1:0]     c_re, c_im;
  logic             c_sat;
  logic [SIDE2-1:0] c_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (advance) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c_mag  <= mag_over ? {(W-1){1'b1}} : mag_shr[W-2:0];
      c_re   <= b_re;
      c_im   <= b_im;
      c_sat  <= b_sat | mag_over;
      c_side <= b_side;
    end
  end

  // --------------------------------------------------------------------------
  // stage d: schur complement clamped to the floor
  // --------------------------------------------------------------------------
  logic [W-1:0] c_p22;
  logic [W-1:0] schur;
  logic         c2_now;

  assign c_p22  = c_side[SIDE2-1 -: W];
  assign schur  = {1'b0, c_p22[W-2:0]} - {1'b0, c_mag};
  assign c2_now = c_p22[W-1] || (c_p22[W-2:0] < c_mag) || (schur[W-2:0] < floor_q);

  logic             d_vld;
  logic [W-2:0]     d_v2;
  logic [SIDE3-1:0] d_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (advance) begin
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      d_v2   <= c2_now ? floor_q : schur[W-2:0];
      d_side <= {c_side[W-2:0], c_re, c_im, c_side[W-1], c2_now, c_sat};
    end
  end

  // --------------------------------------------------------------------------
  // a22 = sqrt(v2); its last register is the output register
  // --------------------------------------------------------------------------
  chf_pkg::pipe_ctl_t sq2_ctl;
  logic [W-2:0]       sq2_root;
  logic [SIDE3-1:0]   sq2_side;

  assign sq2_ctl.valid   = d_vld;
  assign sq2_ctl.advance = advance;

  chf_sqrt_pipe #(
    .IN_BITS   (W-1),
    .FRAC_BITS (FRAC_BITS),
    .SIDE_BITS (SIDE3)
  ) u_sqrt_second (
    .clk       (clk),
    .rst       (rst),
    .ctl       (sq2_ctl),
    .value     (d_v2),
    .side_in   (d_side),
    .valid_out (m_tvalid),
    .root      (sq2_root),
    .side_out  (sq2_side)
  );

  // side: a11, re, im, c1, c2, sat (msb first)
  assign m_tdata = OUT_BITS'({sq2_side[0],                 // saturated
                              sq2_side[1],                 // second_clamped
                              sq2_side[2],                 // first_clamped
                              sq2_root,                    // root_second
                              sq2_side[3 +: W],            // factor_imag
                              sq2_side[W+3 +: W],          // factor_real
                              sq2_side[SIDE3-1 -: W-1]});  // root_first

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  `CHF_ASSERT_IMP(a_root_first_nonzero, clk, rst, m_tvalid, m_tdata[W-2:0] != '0, "a11 is zero")
  `CHF_ASSERT_NXT(a_floor_zero_is_one, clk, rst, pivot_floor_we && (pivot_floor_data == '0), floor_q == (W-1)'(1), "zero floor not stored as one")
  `CHF_ASSERT_NXT(a_stall_holds_entry, clk, rst, a_vld && !advance, a_vld, "entry item lost in stall")

endmodule
